// File: hw/rtl/isl_pkg.sv
// shared types and constants for the sa policy lookup
`timescale 1ns / 1ps
package isl_pkg;
    localparam int MaxEntries = 32;
    localparam int WordsPerEntry = 8;
    localparam int EntryBits = WordsPerEntry * 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam logic [31:0] LtInfinite = 32'hFFFF_FFFF;
    localparam logic [7:0] ProtoAny = 8'd255;
    localparam logic [7:0] ProtoTcp = 8'd6;
    localparam logic [7:0] ProtoUdp = 8'd17;
    localparam logic ActLoad = 1'b0;
    localparam logic ActSearch = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] khi;
        logic [63:0] klo;
        logic [31:0] now;
        logic [5:0] mask;
        logic spiv;
        logic [31:0] spi;
        logic [7:0] proto;
        logic [31:0] ports;
        logic [7:0] my;
    } key_t;

    // result of testing one entry
    typedef struct packed {
        logic expired;
        logic hit;
    } eval_t;
endpackage

// File: hw/rtl/isl_match.sv
// combinational test of one entry against the search key
`timescale 1ns / 1ps
module isl_match
    import isl_pkg::*;
(
    input  logic [EntryBits-1:0] entry,
    input  key_t                 key,
    output eval_t                res
);
    logic [63:0] w [WordsPerEntry];
    logic [31:0] lt;
    logic ported, ok;
    logic [7:0] slen, rlen;

    function automatic logic pfx(input logic [63:0] kh, input logic [63:0] kl,
                                 input logic [63:0] eh, input logic [63:0] el,
                                 input logic [7:0] len);
        logic [127:0] m;
        logic [7:0] l;
        l = (len > 8'd128) ? 8'd128 : len;
        m = (l == 8'd0) ? 128'd0 : ~(128'd0) << (8'd128 - l);
        return ((({kh, kl} ^ {eh, el}) & m) == 128'd0);
    endfunction

    function automatic logic pin(input logic [63:0] pw, input logic [31:0] p);
        return p[31:16] >= pw[63:48] && p[31:16] <= pw[47:32]
            && p[15:0] >= pw[31:16] && p[15:0] <= pw[15:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < WordsPerEntry; i++)
        begin
            w[i] = entry[i*64 +: 64];
        end
        lt = w[0][63:32];
        slen = w[1][23:16];
        rlen = w[1][31:24];
        ported = (key.proto == ProtoTcp) || (key.proto == ProtoUdp);
        res.expired = (lt != LtInfinite) && (lt < key.now);
        ok = 1'b1;
        if (key.mask[0])
        begin
            if (key.spiv)
                ok = ok & w[1][0] & (w[0][31:0] == key.spi);
            else
                ok = ok & ~w[1][0];
        end
        if (key.mask[1])
            ok = ok & ((w[1][15:8] == ProtoAny) || (w[1][15:8] == key.proto));
        if (key.mask[2])
            ok = ok & pfx(key.khi, key.klo, w[2], w[3], slen)
                 & (~ported | pin(w[6], key.ports));
        else if (key.mask[3])
            ok = ok & pfx(key.khi, key.klo, w[4], w[5], rlen)
                 & (~ported | pin(w[7], key.ports));
        if (key.mask[4])
            ok = ok & ((w[1][39:32] & key.my) != 8'd0);
        else if (key.mask[5])
            ok = ok & ((w[1][47:40] & key.my) != 8'd0);
        res.hit = ok & ~res.expired;
    end
endmodule

// File: hw/rtl/ipsec_sa_policy_lookup.sv
// top level: sa and policy table with a first-match scan
`timescale 1ns / 1ps
// a load item writes one 64-bit word of an entry and gives no result.
// a search item with a nonzero query mask scans entries from index zero, one entry per cycle
// out of a wide entry memory (eight words per row, registered read); an expired entry has
// its spi valid bit cleared by a write back to the same row during the scan. the result
// waits in an output register; a new item is taken once it is delivered.
module ipsec_sa_policy_lookup
    import isl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, load_address, data_or_addr_hi, addr_lo, now_time, query_mask,
    // key_spi_valid, key_spi, key_proto, key_ports, key_myself (lowest first), 256 bits
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // match_found, match_index (lowest first)
    output logic [7:0]   m_tdata
);
    // entry memory, one row per entry
    logic [EntryBits-1:0] mem [MaxEntries];
    logic [EntryBits-1:0] rd_q;

    state_t state_reg, state_next;
    logic [5:0] count_reg;
    key_t key_reg;
    logic [IdxW:0] rd_idx_reg, rd_idx_next;   // address being read
    logic [IdxW:0] ev_idx_reg, ev_idx_next;   // entry whose data sits in rd_q
    logic ev_vld_reg, ev_vld_next;
    logic found_reg, found_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [IdxW:0] lim;
    eval_t ev;
    logic acc, ld_we, wb_we;
    logic [IdxW-1:0] ld_row;
    logic [2:0] ld_word;
    logic [EntryBits-1:0] wb_row;

    assign acc = s_tvalid & s_tready;
    assign lim = (count_reg > 6'(MaxEntries)) ? (IdxW+1)'(MaxEntries) : count_reg[IdxW:0];
    assign ld_row = s_tdata[1+3 +: IdxW];
    assign ld_word = s_tdata[3:1];
    assign ld_we = acc && (s_tdata[0] == ActLoad)
                   && ({1'b0, s_tdata[8:1]} < 9'(MaxEntries * WordsPerEntry));

    isl_match u_match (.entry(rd_q), .key(key_reg), .res(ev));

    // the scan never reads an entry after writing it back, so no forwarding is needed
    assign wb_we = ev_vld_reg && ev.expired;
    always_comb
    begin
        wb_row = rd_q;
        wb_row[64] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
            mem[ld_row][ld_word*64 +: 64] <= s_tdata[72:9];
        else if (wb_we)
            mem[ev_idx_reg[IdxW-1:0]] <= wb_row;
        rd_q <= mem[rd_idx_reg[IdxW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 6'd0;
            ev_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            ev_idx_reg <= '0;
            found_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
            ev_vld_reg <= ev_vld_next;
            rd_idx_reg <= rd_idx_next;
            ev_idx_reg <= ev_idx_next;
            found_reg <= found_next;
            idx_reg <= idx_next;
        end
    end

    // key fields in their bus positions
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            key_reg.khi <= s_tdata[72:9];
            key_reg.klo <= s_tdata[136:73];
            key_reg.now <= s_tdata[168:137];
            key_reg.mask <= s_tdata[174:169];
            key_reg.spiv <= s_tdata[175];
            key_reg.spi <= s_tdata[207:176];
            key_reg.proto <= s_tdata[215:208];
            key_reg.ports <= s_tdata[247:216];
            key_reg.my <= s_tdata[255:248];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_idx_next = rd_idx_reg;
        ev_idx_next = rd_idx_reg;
        ev_vld_next = 1'b0;
        found_next = found_reg;
        idx_next = idx_reg;
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_DONE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && s_tdata[0] == ActSearch)
                begin
                    found_next = 1'b0;
                    idx_next = '0;
                    rd_idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue a read while the query mask is nonzero, entries remain and nothing has hit
                if (key_reg.mask != 6'd0 && rd_idx_reg < lim && !(ev_vld_reg && ev.hit))
                begin
                    ev_vld_next = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (ev_vld_reg && ev.hit)
                begin
                    found_next = 1'b1;
                    idx_next = ev_idx_reg[IdxW-1:0];
                    state_next = ST_DONE;
                end
                else if (!ev_vld_next)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {2'b00, 5'(idx_reg), found_reg};

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[5:1] == 5'd0) else $error("index without match");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken during result");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> ev_idx_reg < lim) else $error("scan past table");
endmodule

// File: tb/sv/tb.sv
// testbench for the sa and policy table lookup: directed and random loads and searches
`timescale 1ns / 1ps
module tb;
    import isl_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 60;

    // one input item, the last declared field in the lowest bits
    typedef struct packed {
        logic [7:0]  my;
        logic [31:0] ports;
        logic [7:0]  proto;
        logic [31:0] spi;
        logic        spiv;
        logic [5:0]  mask;
        logic [31:0] now;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  addr;
        logic        act;
    } item_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } hit_t;

    // idling phases
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [5:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    ipsec_sa_policy_lookup u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow copy of the table and register
    logic [63:0] table_shadow [MaxEntries*WordsPerEntry];
    logic [5:0]  count_shadow;
    hit_t        hits_due [$];
    idle_mode_t  idle_mode;
    int          hold_cycles;
    int          errors;
    int          cycles;

    // address pools so that prefixes hit often
    logic [63:0] hi_pool [4];
    logic [63:0] lo_pool [4];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver side: random stalls per phase, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (idle_mode == IDLE_RECV)
            m_tready <= ($urandom_range(99) >= 62);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 7);
        else
            m_tready <= 1'b1;
    end

    // result checker: every delivered item against the oldest expectation
    always @(posedge clk)
    begin
        hit_t got;
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found = m_tdata[0];
            got.idx = m_tdata[5:1];
            if (hits_due.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d index=%0d", $time,
                         got.found, got.idx);
                errors++;
            end
            else
            begin
                want = hits_due.pop_front();
                if (got.found !== want.found)
                begin
                    $display("%0t: match_found expected %0d actual %0d", $time,
                             want.found, got.found);
                    errors++;
                end
                if (got.idx !== want.idx)
                begin
                    $display("%0t: match_index expected %0d actual %0d", $time,
                             want.idx, got.idx);
                    errors++;
                end
            end
        end
    end

    function automatic logic prefix_ok(logic [127:0] k, logic [127:0] e, logic [7:0] len);
        logic [127:0] m;
        int           n;
        n = (len > 128) ? 128 : len;
        m = (n == 0) ? '0 : ~128'h0 << (128 - n);
        return ((k ^ e) & m) == '0;
    endfunction

    function automatic logic ports_ok(logic [63:0] w, logic [15:0] sp, logic [15:0] dp);
        return sp >= w[63:48] && sp <= w[47:32] && dp >= w[31:16] && dp <= w[15:0];
    endfunction

    // first-match search over the shadow table, clearing spi valid on expired entries
    task automatic search_table(input item_t it, output hit_t res);
        int          n;
        int          b;
        logic [63:0] w1;
        logic        ported;
        res = '0;
        ported = (it.proto == ProtoTcp) || (it.proto == ProtoUdp);
        n = (count_shadow > MaxEntries) ? MaxEntries : count_shadow;
        if (it.mask != 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                b = i * WordsPerEntry;
                w1 = table_shadow[b+1];
                if (table_shadow[b][63:32] != LtInfinite && table_shadow[b][63:32] < it.now)
                begin
                    table_shadow[b+1][0] = 1'b0;
                    continue;
                end
                if (it.mask[0])
                begin
                    if (it.spiv && (!w1[0] || table_shadow[b][31:0] != it.spi))
                        continue;
                    if (!it.spiv && w1[0])
                        continue;
                end
                if (it.mask[1] && !(w1[15:8] == ProtoAny || w1[15:8] == it.proto))
                    continue;
                if (it.mask[2])
                begin
                    if (!prefix_ok({it.hi, it.lo}, {table_shadow[b+2], table_shadow[b+3]},
                                   w1[23:16]))
                        continue;
                    if (ported && !ports_ok(table_shadow[b+6], it.ports[31:16], it.ports[15:0]))
                        continue;
                end
                else if (it.mask[3])
                begin
                    if (!prefix_ok({it.hi, it.lo}, {table_shadow[b+4], table_shadow[b+5]},
                                   w1[31:24]))
                        continue;
                    if (ported && !ports_ok(table_shadow[b+7], it.ports[31:16], it.ports[15:0]))
                        continue;
                end
                if (it.mask[4] && (w1[39:32] & it.my) == 0)
                    continue;
                if (!it.mask[4] && it.mask[5] && (w1[47:40] & it.my) == 0)
                    continue;
                res.found = 1'b1;
                res.idx = i[4:0];
                break;
            end
        end
    endtask

    // offers one item and waits for it to be taken, then updates the shadow
    task automatic send_item(input item_t it);
        hit_t r;
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 62) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 7))
            @(negedge clk);
        s_tdata = it;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (it.act == ActLoad)
            table_shadow[it.addr] = it.hi;
        else
        begin
            search_table(it, r);
            hits_due.push_back(r);
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic load_word(input logic [7:0] a, input logic [63:0] w);
        item_t it;
        it = item_t'({$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
        it.act = ActLoad;
        it.addr = a;
        it.hi = w;
        send_item(it);
    endtask

    // a random entry word, biased towards values that can match
    function automatic logic [63:0] entry_word(input int w);
        logic [63:0] v;
        logic [15:0] l;
        logic [15:0] u;
        v = {$urandom, $urandom};
        case (w)
            0: begin
                if ($urandom_range(3) != 0)
                    v[63:32] = ($urandom_range(1) == 0) ? LtInfinite : 32'h8000_0000 + $urandom;
                v[31:0] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
            end
            1: begin
                v[15:8] = ($urandom_range(2) == 0) ? ProtoAny :
                          ($urandom_range(1) == 0) ? ProtoTcp : ProtoUdp;
                if ($urandom_range(4) == 0)
                    v[15:8] = 8'($urandom);
                v[23:16] = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(128));
                v[31:24] = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(128));
            end
            2, 4: if ($urandom_range(3) != 0) v = hi_pool[$urandom_range(3)];
            3, 5: if ($urandom_range(3) != 0) v = lo_pool[$urandom_range(3)];
            default: begin
                if ($urandom_range(3) != 0)
                begin
                    l = 16'($urandom_range(2000));
                    u = l + 16'($urandom_range(60000));
                    v[63:32] = {l, u};
                    l = 16'($urandom_range(2000));
                    u = l + 16'($urandom_range(60000));
                    v[31:0] = {l, u};
                end
            end
        endcase
        return v;
    endfunction

    function automatic item_t rand_search();
        item_t it;
        it = item_t'({$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
        it.act = ActSearch;
        if ($urandom_range(3) != 0)
        begin
            it.hi = hi_pool[$urandom_range(3)];
            it.lo = lo_pool[$urandom_range(3)];
            it.now = ($urandom_range(1) == 0) ? $urandom_range(32'h7FFF_FFFF) : $urandom;
            it.spi = $urandom_range(3);
            it.proto = ($urandom_range(1) == 0) ? ProtoTcp :
                       ($urandom_range(1) == 0) ? ProtoUdp : 8'($urandom);
            it.ports = {16'($urandom_range(3000)), 16'($urandom_range(3000))};
            if ($urandom_range(7) == 0)
                it.ports = $urandom;
        end
        if ($urandom_range(15) == 0)
            it.mask = '0;
        return it;
    endfunction

    // waits for every result and for the block to settle, then writes the register
    task automatic set_count(input logic [5:0] n);
        while (hits_due.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        cfg_wdata = n;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        count_shadow = n;
    endtask

    // fill every word of every entry, some with hand-made corner entries
    task automatic test_table_fill();
        for (int a = 0; a < MaxEntries * WordsPerEntry; a++)
            load_word(a[7:0], entry_word(a % WordsPerEntry));
        // entry 0 expired at most times, entry 1 over-long prefix, entry 2 all ports
        load_word(8'd0, {32'h0000_0010, 32'd1});
        load_word(8'd9, 64'h0000_0000_C8C8_FF01);
        load_word(8'd10, hi_pool[0]);
        load_word(8'd11, lo_pool[0]);
        load_word(8'd22, 64'h0000_FFFF_0000_FFFF);
        load_word(8'd23, 64'h0000_FFFF_0000_FFFF);
    endtask

    // every mask bit, zero and full masks, field extremes
    task automatic test_directed_search();
        item_t it;
        set_count(6'd32);
        for (int m = 0; m < 8; m++)
        begin
            it = rand_search();
            it.mask = (m < 6) ? 6'(1 << m) : (m == 6) ? 6'h3F : 6'h00;
            it.now = (m % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
            it.spiv = m[0];
            send_item(it);
        end
        it = rand_search();
        it.hi = '1;
        it.lo = '1;
        it.ports = '1;
        it.my = '1;
        it.spi = '1;
        it.proto = '1;
        it.mask = 6'h0C;
        send_item(it);
        it.hi = '0;
        it.lo = '0;
        it.ports = '0;
        it.my = '0;
        it.spi = '0;
        it.proto = ProtoTcp;
        send_item(it);
        it = rand_search();
        it.hi = hi_pool[0];
        it.lo = lo_pool[0];
        it.mask = 6'h04;
        send_item(it);
        set_count(6'd0);
        send_item(rand_search());
        set_count(6'd63);
        send_item(rand_search());
        send_item(rand_search());
        set_count(6'd1);
        send_item(rand_search());
    endtask

    // mixed loads and searches through every idling phase and several counts
    task automatic test_random_traffic();
        item_t it;
        for (int p = 0; p < 8; p++)
        begin
            idle_mode = idle_mode_t'(p % 4);
            set_count((p == 3) ? 6'd63 : (p == 5) ? 6'd32 : 6'($urandom_range(1, 40)));
            for (int k = 0; k < 58; k++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    it.addr = 8'($urandom);
                    load_word(it.addr, entry_word(it.addr % WordsPerEntry));
                end
                else
                    send_item(rand_search());
            end
        end
        idle_mode = IDLE_NONE;
    endtask

    // receiver holds off long while searches keep coming
    task automatic test_output_stall();
        set_count(6'd8);
        hold_cycles = 400;
        for (int k = 0; k < 20; k++)
            send_item(rand_search());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        count_shadow = '0;
        idle_mode = IDLE_NONE;
        hi_pool[0] = '1;
        hi_pool[1] = '0;
        lo_pool[0] = '1;
        lo_pool[1] = '0;
        for (int i = 2; i < 4; i++)
        begin
            hi_pool[i] = {$urandom, $urandom};
            lo_pool[i] = {$urandom, $urandom};
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_fill();
        test_directed_search();
        test_random_traffic();
        test_output_stall();

        while (hits_due.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/isl_pkg.sv
hw/rtl/isl_match.sv
hw/rtl/ipsec_sa_policy_lookup.sv
tb/sv/tb.sv
